/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the URI percent encoder.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/upe_pkg.sv */
// Constants and helper functions of the URI percent encoder.
// Depends on nothing; used by uri_percent_encoder.
`default_nettype none
package upe_pkg;

	// Width of one character and the index of a character within a run.
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 3;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// Index of the final character of a run, one per kind of run.
	localparam idx_t IDX_LAST_PASS  = 3'd0;
	localparam idx_t IDX_LAST_ESC   = 3'd2;
	localparam idx_t IDX_LAST_LATIN = 3'd5;

	// Positions inside an escaped run.
	localparam idx_t IDX_PCT_A = 3'd0;
	localparam idx_t IDX_HI_A  = 3'd1;
	localparam idx_t IDX_LO_A  = 3'd2;
	localparam idx_t IDX_PCT_B = 3'd3;
	localparam idx_t IDX_HI_B  = 3'd4;
	localparam idx_t IDX_LO_B  = 3'd5;

	localparam char_t CHAR_PCT   = 8'h25;
	localparam char_t CHAR_SLASH = 8'h2F;

	// True for the unreserved characters of RFC 3986.
	function automatic logic is_unreserved(input char_t c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h5F ||
			c == 8'h2E || c == 8'h7E;
	endfunction

	// Upper-case hex digit for one nibble.
	function automatic char_t hex_char(input logic [3:0] v);
		if (v < 4'd10) begin
			return 8'h30 + {4'h0, v};
		end else begin
			return 8'h37 + {4'h0, v};
		end
	endfunction

endpackage
`default_nettype wire

/* rtl/uri_percent_encoder.sv */
// Top level of the URI percent encoder: input register, character select, result register.
// Depends on upe_pkg and assert_macros.svh.
//
// Usage: a byte word is offered on in_byte with start high; it is taken at a rising
// edge where start is high and busy is low. Each byte yields a run of 1, 3 or 6
// characters: a passed byte, %HH, or %C2/%C3 followed by %HH for bytes of 128 and up.
// Characters leave one per cycle on out_char with out_strobe high for exactly one
// cycle each; last_of_run marks the final character of a run.
// The first character goes through the input register, then the result register.
// The rate of bytes is set by their run lengths and by the single result register, which
// sends one character per cycle. busy drops in the cycle that forms the last character
// of a run, the cycle before that character reaches the ports, so the next byte follows
// with no gap.
// The receiver cannot stall; every strobed word must be taken when it appears. The user
// writes pass_slash through cfg_we/cfg_wdata only while the block is idle; not enforced.
// Reset (arst_n low) clears pass_slash, ends any run and removes the strobe.
`default_nettype none
`include "assert_macros.svh"
module uri_percent_encoder
	import upe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] in_byte,
	output logic            out_strobe,
	output logic [7:0]      out_char,
	output logic            last_of_run
);

	logic  pass_slash_q;
	logic  act_q;
	char_t byte_s1;
	idx_t  idx_q;
	idx_t  last_idx_q;
	logic  last_now;
	logic  accept;
	char_t esc_val;
	char_t char_sel;
	idx_t  last_idx_in;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_slash_q <= 1'b0;
		end else if (cfg_we) begin
			pass_slash_q <= cfg_wdata;
		end
	end

	// Run length of an incoming byte, as the index of its last character.
	always_comb begin
		if (is_unreserved(in_byte) || (in_byte == CHAR_SLASH && pass_slash_q)) begin
			last_idx_in = IDX_LAST_PASS;
		end else if (!in_byte[7]) begin
			last_idx_in = IDX_LAST_ESC;
		end else begin
			last_idx_in = IDX_LAST_LATIN;
		end
	end

	// Handshake: a new byte is taken when idle or during the last character of a run.
	assign last_now = (idx_q == last_idx_q);
	assign busy     = act_q && !last_now;
	assign accept   = start && !busy;

	// Input register and character counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q      <= 1'b0;
			idx_q      <= '0;
			last_idx_q <= '0;
		end else if (accept) begin
			act_q      <= 1'b1;
			idx_q      <= '0;
			last_idx_q <= last_idx_in;
		end else if (act_q && last_now) begin
			act_q <= 1'b0;
		end else if (act_q) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
		end
	end

	// Value being escaped: the byte itself, or one of its two UTF-8 bytes.
	always_comb begin
		if (last_idx_q == IDX_LAST_ESC) begin
			esc_val = byte_s1;
		end else if (idx_q < IDX_PCT_B) begin
			esc_val = {6'b110000, byte_s1[7:6]};
		end else begin
			esc_val = {2'b10, byte_s1[5:0]};
		end
	end

	// Character for the current position of the run.
	always_comb begin
		if (last_idx_q == IDX_LAST_PASS) begin
			char_sel = byte_s1;
		end else begin
			case (idx_q) inside
				IDX_PCT_A, IDX_PCT_B: char_sel = CHAR_PCT;
				IDX_HI_A, IDX_HI_B:   char_sel = hex_char(esc_val[7:4]);
				IDX_LO_A, IDX_LO_B:   char_sel = hex_char(esc_val[3:0]);
				default:              char_sel = CHAR_PCT;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_strobe <= 1'b0;
		end else begin
			out_strobe <= act_q;
		end
	end

	always_ff @(posedge clk) begin
		out_char    <= char_sel;
		last_of_run <= last_now;
	end

	// A run is never cut short: a strobe without the last marker is followed by another.
	`ASSERT_NEXT(a_run_continues, out_strobe && !last_of_run, out_strobe)
	// Every active cycle of the input register puts one word on the result ports.
	`ASSERT_NEXT(a_act_strobes, act_q, out_strobe)
	// An accepted byte starts its run at the first character.
	`ASSERT_NEXT(a_accept_starts, accept, act_q && idx_q == IDX_PCT_A)
	// The counter never passes the last character of its run.
	`ASSERT_SAME(a_idx_bound, act_q, idx_q <= last_idx_q)

endmodule
`default_nettype wire

/* verif/uri_percent_encoder_tb.sv */
// Self-checking testbench for uri_percent_encoder: drives byte words, predicts every
// encoded character and compares each strobed character against that prediction.
// Depends on upe_pkg and the RTL of the encoder; reads no files.
`timescale 1ns / 100ps
module uri_percent_encoder_tb;
	import upe_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int MAX_SHOWN  = 10;
	localparam int RAND_PHASE = 125;

	// One predicted character and its end-of-run mark.
	typedef struct packed {
		char_t ch;
		logic  last;
	} enc_char_t;

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	logic  cfg_wdata;
	logic  start;
	logic  busy;
	char_t in_byte;
	logic  out_strobe;
	char_t out_char;
	logic  last_of_run;

	enc_char_t exp_chars[$];
	logic      slash_shadow = 1'b0;
	int        bytes_taken  = 0;
	int        chars_seen   = 0;
	int        idle_cycles  = 0;
	int        mismatches   = 0;
	int        n_passed     = 0;
	int        n_escaped    = 0;
	int        n_latin      = 0;

	uri_percent_encoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.in_byte    (in_byte),
		.out_strobe (out_strobe),
		.out_char   (out_char),
		.last_of_run(last_of_run)
	);

	// Free-running clock with a 4 ns period.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// RFC 3986 unreserved set, checked against a literal list of characters.
	function automatic bit is_plain_char(input char_t c);
		string keep;
		keep = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_.~";
		for (int i = 0; i < keep.len(); i++) begin
			if (keep[i] == c)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic char_t hex_ascii(input logic [3:0] n);
		string digits;
		digits = "0123456789ABCDEF";
		return digits[n];
	endfunction

	// Append one expected character at the tail of the queue.
	function automatic void push_char(input char_t c, input logic last);
		enc_char_t e;
		e.ch   = c;
		e.last = last;
		exp_chars.insert(exp_chars.size(), e);
	endfunction

	function automatic void push_escape(input char_t v, input logic last);
		push_char(CHAR_PCT, 1'b0);
		push_char(hex_ascii(v[7:4]), 1'b0);
		push_char(hex_ascii(v[3:0]), last);
	endfunction

	// Expected characters for one accepted byte under the current slash setting.
	function automatic void predict_encoding(input char_t b);
		if (is_plain_char(b) || (b == CHAR_SLASH && slash_shadow)) begin
			push_char(b, 1'b1);
			n_passed++;
		end else if (b < 8'h80) begin
			push_escape(b, 1'b1);
			n_escaped++;
		end else begin
			// Latin-1 byte as two-byte UTF-8: lead byte C2 or C3, then 80..BF.
			push_escape(8'hC0 | (b >> 6), 1'b0);
			push_escape(8'h80 | (b & 8'h3F), 1'b1);
			n_latin++;
		end
	endfunction

	// Sample the ports at each rising edge: check the strobed character, then record
	// an accepted byte word and any register write.
	always @(posedge clk) begin
		enc_char_t e;
		bit        moved;
		if (arst_n) begin
			moved = 1'b0;
			if (out_strobe === 1'b1) begin
				moved = 1'b1;
				chars_seen++;
				if (exp_chars.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("unexpected character %02h last=%0b", out_char, last_of_run);
				end else begin
					e = exp_chars.pop_front();
					if (out_char !== e.ch || last_of_run !== e.last) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("mismatch: expected %02h last=%0b, got %02h last=%0b",
								e.ch, e.last, out_char, last_of_run);
					end
				end
			end
			if (start && busy === 1'b0) begin
				moved = 1'b1;
				predict_encoding(in_byte);
				bytes_taken++;
			end
			if (cfg_we)
				slash_shadow = cfg_wdata;
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// Watchdog: too long without any word moving ends the run.
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// Offer one byte word; called and returning on a falling edge. start stays high so
	// that a following word goes out with no gap.
	task automatic send_byte(input char_t b);
		int taken_before;
		taken_before = bytes_taken;
		start   = 1'b1;
		in_byte = b;
		while (bytes_taken == taken_before)
			@(negedge clk);
	endtask

	// Release start and wait until every predicted character has come out.
	task automatic drain_chars();
		start = 1'b0;
		@(negedge clk);
		while (exp_chars.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_pass_slash(input logic v);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Edge bytes: NUL, small and large hex values, every kind of run and the
	// Latin-1 second byte range.
	task automatic test_directed_bytes();
		char_t list[] = '{8'h00, 8'h0F, 8'h10, 8'h20, 8'h25, 8'h2F, 8'h41, 8'h5A,
			8'h61, 8'h7A, 8'h30, 8'h39, 8'h2D, 8'h5F, 8'h2E, 8'h7E, 8'h40, 8'h7F,
			8'h80, 8'hBF, 8'hC0, 8'hFF};
		write_pass_slash(1'b0);
		foreach (list[i])
			send_byte(list[i]);
		drain_chars();
	endtask

	// Slash passes only when enabled; other bytes do not depend on the setting.
	task automatic test_slash_modes();
		write_pass_slash(1'b1);
		send_byte(CHAR_SLASH);
		send_byte(CHAR_PCT);
		send_byte(8'hE9);
		drain_chars();
		write_pass_slash(1'b0);
		send_byte(CHAR_SLASH);
		drain_chars();
	endtask

	// Random byte biased toward each kind of run, with a share of fully random values.
	function automatic char_t pick_byte();
		string keep;
		keep = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_.~";
		case ($urandom_range(0, 9)) inside
			0, 1, 2: return char_t'($urandom_range(0, 255));
			3, 4:    return keep[$urandom_range(0, keep.len() - 1)];
			5:       return CHAR_SLASH;
			6, 7:    return char_t'($urandom_range(0, 127));
			default: return char_t'($urandom_range(128, 255));
		endcase
	endfunction

	// Random stream in bursts with random gaps, over alternating slash settings;
	// the third phase runs without any gap.
	task automatic test_random_stream();
		int left;
		int burst;
		int gap;
		for (int phase = 0; phase < 4; phase++) begin
			write_pass_slash(phase % 2 == 0);
			left = RAND_PHASE;
			while (left > 0) begin
				burst = $urandom_range(1, 16);
				for (int i = 0; i < burst && left > 0; i++) begin
					send_byte(pick_byte());
					left--;
				end
				gap = (phase == 2 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					start   = 1'b0;
					in_byte = char_t'($urandom);
					repeat (gap) @(negedge clk);
				end
			end
			drain_chars();
		end
	endtask

	// Reset, run the tests in turn, then report.
	initial begin
		int leftover;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		start     = 1'b0;
		in_byte   = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_bytes();
		test_slash_modes();
		test_random_stream();
		leftover = exp_chars.size();
		$display("Encoded %0d bytes (%0d passed, %0d escaped, %0d Latin-1), slash on and off.",
			bytes_taken, n_passed, n_escaped, n_latin);
		$display("Checked %0d characters; %0d mismatches, %0d missing.",
			chars_seen, mismatches, leftover);
		if (mismatches == 0 && leftover == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
